[hw/rtl/dpf_pkg.sv]
// dpf_pkg: shared types, codes and default sizes for the duplicate packet filter.
// Used by every module under hw/rtl; depends on nothing else.
package dpf_pkg;

    localparam int DPF_ACK_DEPTH   = 32;
    localparam int DPF_HASH_DEPTH  = 32;
    localparam int DPF_HASH_BYTES  = 8;
    localparam int DPF_QUEUE_DEPTH = 2;

    // Action codes as they arrive on the input word.
    localparam logic [1:0] ACT_CHECK  = 2'd0;
    localparam logic [1:0] ACT_CLEAR  = 2'd1;
    localparam logic [1:0] ACT_RSTAT  = 2'd2;

    typedef enum logic [1:0] {
        OP_CHECK,
        OP_CLEAR,
        OP_RSTAT,
        OP_NOP
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } t_back_state;

    typedef struct packed {
        logic [1:0]  action;
        logic        is_ack;
        logic        is_direct;
        logic [31:0] ack_value;
        logic [63:0] packet_hash;
    } t_in;

    typedef struct packed {
        logic        seen;
        logic [31:0] direct_dup_count;
        logic [31:0] flood_dup_count;
    } t_out;

    // Classified command handed from the front to the back through the queue.
    typedef struct packed {
        t_op         op;
        logic        is_ack;
        logic        is_direct;
        logic [31:0] ack_key;
        logic [63:0] hash_key;
    } t_cmd;

    typedef struct packed {
        logic not_empty;
        logic not_full;
    } t_q_stat;

endpackage

[hw/rtl/dpf_front.sv]
// dpf_front: input register that accepts words, decodes the action and masks the hash.
// Depends on dpf_pkg; feeds dpf_queue.
module dpf_front import dpf_pkg::*; #(
    parameter int HASH_BYTES = DPF_HASH_BYTES
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_in     i_data,
    input  t_q_stat i_q_stat,
    output logic    o_push,
    output t_cmd    o_cmd
);

    localparam logic [63:0] HashMask = (HASH_BYTES >= 8) ? {64{1'b1}} :
                                       ((64'd1 << (8 * HASH_BYTES)) - 64'd1);

    logic r_valid, n_valid;
    t_cmd r_cmd, n_cmd;
    logic accept;

    assign o_push  = r_valid && i_q_stat.not_full;
    assign o_ready = !r_valid || i_q_stat.not_full;
    assign accept  = i_valid && o_ready;
    assign o_cmd   = r_cmd;

    always_comb begin
        n_cmd.is_ack    = i_data.is_ack;
        n_cmd.is_direct = i_data.is_direct;
        n_cmd.ack_key   = i_data.ack_value;
        n_cmd.hash_key  = i_data.packet_hash & HashMask;
        unique case (i_data.action)
            ACT_CHECK: n_cmd.op = OP_CHECK;
            ACT_CLEAR: n_cmd.op = OP_CLEAR;
            ACT_RSTAT: n_cmd.op = OP_RSTAT;
            default:   n_cmd.op = OP_NOP;
        endcase
    end

    always_comb begin
        if (accept) begin
            n_valid = 1'b1;
        end else if (o_push) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

[hw/rtl/dpf_queue.sv]
// dpf_queue: short command queue between the front and the back.
// Depends on dpf_pkg for the command type and depth.
module dpf_queue import dpf_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_cmd    i_cmd,
    input  logic    i_pop,
    output t_cmd    o_head,
    output t_q_stat o_stat
);

    localparam int PtrW = (DPF_QUEUE_DEPTH > 1) ? $clog2(DPF_QUEUE_DEPTH) : 1;
    localparam int CntW = $clog2(DPF_QUEUE_DEPTH + 1);

    t_cmd            r_mem [DPF_QUEUE_DEPTH];
    logic [PtrW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CntW-1:0] r_count;
    logic            do_push, do_pop;

    assign o_stat.not_empty = (r_count != '0);
    assign o_stat.not_full  = (r_count != CntW'(DPF_QUEUE_DEPTH));
    assign do_push = i_push && o_stat.not_full;
    assign do_pop  = i_pop && o_stat.not_empty;
    assign o_head  = r_mem[r_rd_ptr];

    function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
        ptr_inc = (p == PtrW'(DPF_QUEUE_DEPTH - 1)) ? '0 : p + PtrW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CntW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CntW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

[hw/rtl/dpf_back.sv]
// dpf_back: key stores, one-entry-per-cycle scan, counters and the result register.
// Depends on dpf_pkg; takes commands from dpf_queue.
module dpf_back import dpf_pkg::*; #(
    parameter int ACK_DEPTH  = DPF_ACK_DEPTH,
    parameter int HASH_DEPTH = DPF_HASH_DEPTH,
    parameter int HASH_BYTES = DPF_HASH_BYTES
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_q_stat i_q_stat,
    input  t_cmd    i_head,
    output logic    o_pop,
    output logic    o_valid,
    input  logic    i_ready,
    output t_out    o_data
);

    localparam int AckAw    = $clog2(ACK_DEPTH);
    localparam int HashAw   = $clog2(HASH_DEPTH);
    localparam int HashBits = 8 * HASH_BYTES;
    localparam int MaxDepth = (ACK_DEPTH > HASH_DEPTH) ? ACK_DEPTH : HASH_DEPTH;
    localparam int CntW     = $clog2(MaxDepth + 1);

    t_back_state r_state, n_state;
    t_cmd        r_cmd;

    logic [31:0]       r_ack_mem  [ACK_DEPTH];
    logic [HashBits-1:0] r_hash_mem [HASH_DEPTH];
    logic [ACK_DEPTH-1:0]  r_ack_vld;
    logic [HASH_DEPTH-1:0] r_hash_vld;

    logic [31:0]         r_ack_q;
    logic                r_ack_vq;
    logic [HashBits-1:0] r_hash_q;
    logic                r_hash_vq;

    logic [CntW-1:0]   r_rd_idx, r_rd_at, r_hit_idx;
    logic              r_rd_pend, r_hit;
    logic [AckAw-1:0]  r_ack_slot;
    logic [HashAw-1:0] r_hash_slot;
    logic [31:0]       r_direct_dups, r_flood_dups, n_direct, n_flood;
    logic              r_out_valid;
    t_out              r_out;

    logic [CntW-1:0] sel_depth;
    logic            rd_en, ack_re, hash_re;
    logic            entry_match, last_entry, scan_done;
    logic            out_free, do_fin, ack_we, hash_we;
    logic [31:0]         ack_entry;
    logic [HashBits-1:0] hash_entry;

    assign sel_depth  = r_cmd.is_ack ? CntW'(ACK_DEPTH) : CntW'(HASH_DEPTH);
    assign ack_entry  = r_ack_vq ? r_ack_q : 32'd0;
    assign hash_entry = r_hash_vq ? r_hash_q : '0;
    assign entry_match = r_cmd.is_ack ? (ack_entry == r_cmd.ack_key)
                                      : (hash_entry == r_cmd.hash_key[HashBits-1:0]);
    assign last_entry = (r_rd_at == sel_depth - CntW'(1));
    assign out_free   = !r_out_valid || i_ready;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_q_stat.not_empty) begin
                    if (i_head.op == OP_CHECK || i_head.op == OP_CLEAR) begin
                        n_state = ST_SCAN;
                    end else begin
                        n_state = ST_UPDATE;
                    end
                end
            end
            ST_SCAN: begin
                if (scan_done) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        o_pop     = (r_state == ST_IDLE) && i_q_stat.not_empty;
        rd_en     = (r_state == ST_SCAN) && (r_rd_idx < sel_depth);
        scan_done = (r_state == ST_SCAN) && r_rd_pend && (entry_match || last_entry);
        do_fin    = (r_state == ST_UPDATE) && out_free;
    end

    assign ack_re  = rd_en && r_cmd.is_ack;
    assign hash_re = rd_en && !r_cmd.is_ack;
    assign ack_we  = do_fin && (r_cmd.op == OP_CHECK) && !r_hit && r_cmd.is_ack;
    assign hash_we = do_fin && (r_cmd.op == OP_CHECK) && !r_hit && !r_cmd.is_ack;

    always_comb begin
        n_direct = r_direct_dups;
        n_flood  = r_flood_dups;
        unique case (r_cmd.op)
            OP_CHECK: begin
                if (r_hit) begin
                    if (r_cmd.is_direct) begin
                        n_direct = r_direct_dups + 32'd1;
                    end else begin
                        n_flood = r_flood_dups + 32'd1;
                    end
                end
            end
            OP_RSTAT: begin
                n_direct = 32'd0;
                n_flood  = 32'd0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_rd_idx      <= '0;
            r_rd_pend     <= 1'b0;
            r_ack_slot    <= '0;
            r_hash_slot   <= '0;
            r_direct_dups <= 32'd0;
            r_flood_dups  <= 32'd0;
            r_out_valid   <= 1'b0;
            r_ack_vld     <= '0;
            r_hash_vld    <= '0;
        end else begin
            r_state <= n_state;
            if (o_pop) begin
                r_rd_idx  <= '0;
                r_rd_pend <= 1'b0;
            end else if (r_state == ST_SCAN) begin
                r_rd_pend <= rd_en;
                if (rd_en) begin
                    r_rd_idx <= r_rd_idx + CntW'(1);
                end
            end
            if (do_fin) begin
                r_direct_dups <= n_direct;
                r_flood_dups  <= n_flood;
                r_out_valid   <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (ack_we) begin
                r_ack_vld[r_ack_slot] <= 1'b1;
                r_ack_slot <= (r_ack_slot == AckAw'(ACK_DEPTH - 1)) ? '0
                                                                     : r_ack_slot + AckAw'(1);
            end
            if (hash_we) begin
                r_hash_vld[r_hash_slot] <= 1'b1;
                r_hash_slot <= (r_hash_slot == HashAw'(HASH_DEPTH - 1)) ? '0
                                                                         : r_hash_slot + HashAw'(1);
            end
            // A cleared entry simply drops its valid bit and reads as zero.
            if (do_fin && r_cmd.op == OP_CLEAR && r_hit) begin
                if (r_cmd.is_ack) begin
                    r_ack_vld[r_hit_idx[AckAw-1:0]] <= 1'b0;
                end else begin
                    r_hash_vld[r_hit_idx[HashAw-1:0]] <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_head;
        end
        if (rd_en) begin
            r_rd_at <= r_rd_idx;
        end
        if (scan_done) begin
            r_hit     <= entry_match;
            r_hit_idx <= r_rd_at;
        end
        if (do_fin) begin
            r_out.seen             <= (r_cmd.op == OP_CHECK) && r_hit;
            r_out.direct_dup_count <= n_direct;
            r_out.flood_dup_count  <= n_flood;
        end
    end

    // Ack store: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (ack_we) begin
            r_ack_mem[r_ack_slot] <= r_cmd.ack_key;
        end
        if (ack_re) begin
            r_ack_q  <= r_ack_mem[r_rd_idx[AckAw-1:0]];
            r_ack_vq <= r_ack_vld[r_rd_idx[AckAw-1:0]];
        end
    end

    // Hash store: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (hash_we) begin
            r_hash_mem[r_hash_slot] <= r_cmd.hash_key[HashBits-1:0];
        end
        if (hash_re) begin
            r_hash_q  <= r_hash_mem[r_rd_idx[HashAw-1:0]];
            r_hash_vq <= r_hash_vld[r_rd_idx[HashAw-1:0]];
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && r_rd_pend) |-> (r_rd_at < sel_depth))
        else $error("scan compared an entry beyond the selected store");

    a_update_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPDATE && !out_free) |=> (r_state == ST_UPDATE))
        else $error("update left while the result register was occupied");

    a_result_from_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_UPDATE))
        else $error("result appeared without an update step");

    a_miss_keeps_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_fin && r_cmd.op == OP_CHECK && !r_hit)
        |=> (r_direct_dups == $past(r_direct_dups) && r_flood_dups == $past(r_flood_dups)))
        else $error("a check that missed changed a duplicate counter");

endmodule

[hw/rtl/duplicate_packet_filter.sv]
// Duplicate packet filter: front register, two-entry command queue, scanning back end.
// A check or clear scans the selected store and a hit ends the scan early. The back end
// finishes one word, scanning one store entry per cycle on a single read port, before it takes
// the next word from the queue. Counter resets and unused actions skip the scan and go
// straight to the update step. Synchronous reset clears all valid bits, slot pointers and
// counters at once, so every store entry then reads as zero.
module duplicate_packet_filter import dpf_pkg::*; #(
    parameter int ACK_DEPTH  = DPF_ACK_DEPTH,
    parameter int HASH_DEPTH = DPF_HASH_DEPTH,
    parameter int HASH_BYTES = DPF_HASH_BYTES
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_data
);

    t_q_stat q_stat;
    t_cmd    front_cmd, q_head;
    logic    push, pop;

    dpf_front #(
        .HASH_BYTES(HASH_BYTES)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_data   (i_data),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_cmd    (front_cmd)
    );

    dpf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_head  (q_head),
        .o_stat  (q_stat)
    );

    dpf_back #(
        .ACK_DEPTH  (ACK_DEPTH),
        .HASH_DEPTH (HASH_DEPTH),
        .HASH_BYTES (HASH_BYTES)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_stat (q_stat),
        .i_head   (q_head),
        .o_pop    (pop),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_data   (o_data)
    );

endmodule

[bench/tb_duplicate_packet_filter.sv]
// Self-checking testbench for duplicate_packet_filter: a directed table, then random words.
// Expected results come from the table or an in-bench model of the key tables and counters.
// Depends on dpf_pkg and the duplicate_packet_filter RTL only.
`timescale 1ns / 100ps

module tb_duplicate_packet_filter;
    import dpf_pkg::*;

    // Action value that the block must ignore apart from reporting the counts.
    localparam logic [1:0] ACT_NONE = 2'd3;
    localparam logic [63:0] HASH_KEY_MASK = (DPF_HASH_BYTES >= 8) ? {64{1'b1}} :
                                            ((64'd1 << (DPF_HASH_BYTES * 8)) - 64'd1);
    localparam int KEY_POOL_SIZE = 48;
    localparam int DRAIN_CYCLES  = 80;

    typedef struct {
        t_in  word;
        bit   typed;
        t_out verdict;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_valid;
    logic o_ready;
    t_in  i_data;
    logic o_valid;
    logic i_ready;
    t_out o_data;

    // Model state of the filter.
    logic [31:0] ack_keys [DPF_ACK_DEPTH];
    logic [63:0] hash_keys [DPF_HASH_DEPTH];
    int          ack_slot;
    int          hash_slot;
    logic [31:0] direct_cnt;
    logic [31:0] flood_cnt;

    t_out        expected_verdicts [$];
    t_row        directed_rows [$];
    logic [31:0] recent_acks [$];
    logic [63:0] recent_hashes [$];
    int          mismatches = 0;
    bit          quiet = 1'b0;

    duplicate_packet_filter dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else if (r < 98) begin
            return $urandom_range(4, 20);
        end
        return $urandom_range(50, 150);
    endfunction

    // Applies one word to the model tables and returns the result it must produce.
    function automatic t_out filter_step(input t_in w);
        t_out        r;
        logic [63:0] hkey;
        bit          hit;
        hkey = w.packet_hash & HASH_KEY_MASK;
        hit = 1'b0;
        case (w.action)
            ACT_CHECK: begin
                if (w.is_ack) begin
                    for (int i = 0; i < DPF_ACK_DEPTH; i++) begin
                        if (ack_keys[i] == w.ack_value) hit = 1'b1;
                    end
                    if (!hit) begin
                        ack_keys[ack_slot] = w.ack_value;
                        ack_slot = (ack_slot == DPF_ACK_DEPTH - 1) ? 0 : ack_slot + 1;
                    end
                end else begin
                    for (int i = 0; i < DPF_HASH_DEPTH; i++) begin
                        if (hash_keys[i] == hkey) hit = 1'b1;
                    end
                    if (!hit) begin
                        hash_keys[hash_slot] = hkey;
                        hash_slot = (hash_slot == DPF_HASH_DEPTH - 1) ? 0 : hash_slot + 1;
                    end
                end
                if (hit && w.is_direct) begin
                    direct_cnt = direct_cnt + 32'd1;
                end else if (hit) begin
                    flood_cnt = flood_cnt + 32'd1;
                end
            end
            ACT_CLEAR: begin
                // Only the lowest matching entry is zeroed.
                if (w.is_ack) begin
                    for (int i = 0; i < DPF_ACK_DEPTH; i++) begin
                        if (!hit && ack_keys[i] == w.ack_value) begin
                            ack_keys[i] = '0;
                            hit = 1'b1;
                        end
                    end
                end else begin
                    for (int i = 0; i < DPF_HASH_DEPTH; i++) begin
                        if (!hit && hash_keys[i] == hkey) begin
                            hash_keys[i] = '0;
                            hit = 1'b1;
                        end
                    end
                end
                hit = 1'b0;
            end
            ACT_RSTAT: begin
                direct_cnt = '0;
                flood_cnt = '0;
            end
            default: begin
            end
        endcase
        r.seen = hit;
        r.direct_dup_count = direct_cnt;
        r.flood_dup_count = flood_cnt;
        return r;
    endfunction

    function automatic t_in random_word();
        t_in w;
        int  r;
        int  k;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            w.action = ACT_CHECK;
        end else if (r < 85) begin
            w.action = ACT_CLEAR;
        end else if (r < 92) begin
            w.action = ACT_RSTAT;
        end else begin
            w.action = ACT_NONE;
        end
        w.is_ack = 1'($urandom_range(0, 1));
        w.is_direct = 1'($urandom_range(0, 1));
        w.ack_value = $urandom;
        w.packet_hash = {$urandom, $urandom};
        // Often reuse recent keys so that checks and clears find matches.
        r = $urandom_range(0, 99);
        k = $urandom_range(0, 63);
        if (w.is_ack) begin
            if (r < 45 && recent_acks.size() > 0) begin
                w.ack_value = recent_acks[$urandom_range(0, recent_acks.size() - 1)];
            end else if (r < 55) begin
                w.ack_value = '0;
            end else if (r < 65) begin
                case ($urandom_range(0, 2))
                    0: w.ack_value = '1;
                    1: w.ack_value = 32'd1 << k[4:0];
                    default: w.ack_value = ~(32'd1 << k[4:0]);
                endcase
            end
        end else begin
            if (r < 45 && recent_hashes.size() > 0) begin
                w.packet_hash = recent_hashes[$urandom_range(0, recent_hashes.size() - 1)];
            end else if (r < 55) begin
                w.packet_hash = '0;
            end else if (r < 65) begin
                case ($urandom_range(0, 2))
                    0: w.packet_hash = '1;
                    1: w.packet_hash = 64'd1 << k;
                    default: w.packet_hash = ~(64'd1 << k);
                endcase
            end
        end
        return w;
    endfunction

    task automatic add_row(input logic [1:0] act, input bit ack, input bit dir,
                           input logic [31:0] av, input logic [63:0] hv, input bit typed,
                           input bit sn, input logic [31:0] dc, input logic [31:0] fc);
        t_row row;
        row.word.action = act;
        row.word.is_ack = ack;
        row.word.is_direct = dir;
        row.word.ack_value = av;
        row.word.packet_hash = hv;
        row.typed = typed;
        row.verdict.seen = sn;
        row.verdict.direct_dup_count = dc;
        row.verdict.flood_dup_count = fc;
        directed_rows.push_back(row);
    endtask

    // Presents one word and returns at the edge where it is accepted.
    task automatic offer_word(input t_in w);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= w;
        do @(posedge i_clk); while (!o_ready);
    endtask

    initial begin : source
        t_in  w;
        t_out v;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data = '0;
        foreach (ack_keys[i]) ack_keys[i] = '0;
        foreach (hash_keys[i]) hash_keys[i] = '0;
        ack_slot = 0;
        hash_slot = 0;
        direct_cnt = '0;
        flood_cnt = '0;

        // After reset every entry is zero, so a zero key is already seen.
        add_row(ACT_CHECK, 0, 0, 32'hDEAD_BEEF, 64'h0, 1, 1, 32'd0, 32'd1);
        add_row(ACT_CHECK, 1, 1, 32'h0, 64'h0123_4567_89AB_CDEF, 1, 1, 32'd1, 32'd1);
        add_row(ACT_CHECK, 1, 1, 32'hFFFF_FFFF, 64'h0, 1, 0, 32'd1, 32'd1);
        add_row(ACT_CHECK, 1, 1, 32'hFFFF_FFFF, 64'h0, 1, 1, 32'd2, 32'd1);
        add_row(ACT_CHECK, 0, 0, 32'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1, 0, 32'd2, 32'd1);
        add_row(ACT_CHECK, 0, 0, 32'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1, 1, 32'd2, 32'd2);
        add_row(ACT_CLEAR, 0, 1, 32'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1, 0, 32'd2, 32'd2);
        add_row(ACT_CHECK, 0, 1, 32'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1, 0, 32'd2, 32'd2);
        add_row(ACT_NONE, 1, 1, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1, 0, 32'd2, 32'd2);
        add_row(ACT_RSTAT, 1, 1, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1, 0, 32'd0, 32'd0);
        add_row(ACT_CHECK, 1, 0, 32'h8000_0000, 64'h0, 1, 0, 32'd0, 32'd0);
        add_row(ACT_CHECK, 1, 1, 32'h8000_0000, 64'h0, 1, 1, 32'd1, 32'd0);
        add_row(ACT_CLEAR, 1, 0, 32'h8000_0000, 64'h0, 1, 0, 32'd1, 32'd0);
        add_row(ACT_CLEAR, 1, 1, 32'h0, 64'h0, 1, 0, 32'd1, 32'd0);
        add_row(ACT_CHECK, 0, 0, 32'h0, 64'h8000_0000_0000_0001, 1, 0, 32'd1, 32'd0);
        add_row(ACT_CHECK, 0, 0, 32'h0, 64'h0000_0000_0000_0001, 1, 0, 32'd1, 32'd0);
        add_row(ACT_CHECK, 0, 1, 32'h0, 64'h8000_0000_0000_0001, 1, 1, 32'd2, 32'd0);
        add_row(ACT_RSTAT, 0, 0, 32'h0, 64'h0, 1, 0, 32'd0, 32'd0);
        add_row(ACT_CHECK, 1, 1, 32'h5555_AAAA, 64'hAAAA_5555_AAAA_5555, 0, 0, 32'd0, 32'd0);
        add_row(ACT_CHECK, 1, 0, 32'hAAAA_5555, 64'h5555_AAAA_5555_AAAA, 0, 0, 32'd0, 32'd0);
        add_row(ACT_CLEAR, 0, 0, 32'h1234_5678, 64'h0000_0000_0000_0001, 0, 0, 32'd0, 32'd0);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[n]) begin
            offer_word(directed_rows[n].word);
            v = filter_step(directed_rows[n].word);
            expected_verdicts.push_back(directed_rows[n].typed ? directed_rows[n].verdict : v);
        end

        for (int n = 0; n < 500; n++) begin
            if (n == 150 || n == 400) begin
                // Let the block run dry before the next word.
                i_valid <= 1'b0;
                while (expected_verdicts.size() != 0) @(posedge i_clk);
            end
            if ($urandom_range(0, 59) == 0) quiet = ~quiet;
            w = random_word();
            offer_word(w);
            expected_verdicts.push_back(filter_step(w));
            if (w.action == ACT_CHECK && w.is_ack) begin
                recent_acks.push_back(w.ack_value);
                if (recent_acks.size() > KEY_POOL_SIZE) void'(recent_acks.pop_front());
            end else if (w.action == ACT_CHECK) begin
                recent_hashes.push_back(w.packet_hash);
                if (recent_hashes.size() > KEY_POOL_SIZE) void'(recent_hashes.pop_front());
            end
        end
        i_valid <= 1'b0;

        while (expected_verdicts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin : sink
        int   stall_left;
        t_out e;
        i_ready = 1'b0;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                if (expected_verdicts.size() == 0) begin
                    $error("result word with nothing expected: %h", o_data);
                    mismatches++;
                end else begin
                    e = expected_verdicts.pop_front();
                    if (o_data.seen !== e.seen) begin
                        $error("seen: expected %0d, got %0d", e.seen, o_data.seen);
                        mismatches++;
                    end
                    if (o_data.direct_dup_count !== e.direct_dup_count) begin
                        $error("direct_dup_count: expected %0d, got %0d",
                               e.direct_dup_count, o_data.direct_dup_count);
                        mismatches++;
                    end
                    if (o_data.flood_dup_count !== e.flood_dup_count) begin
                        $error("flood_dup_count: expected %0d, got %0d",
                               e.flood_dup_count, o_data.flood_dup_count);
                        mismatches++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

endmodule
